/* sv/soldering_iron_temperature_controller_top_defines.svh */
// Assertion macros for the soldering iron temperature controller.
`ifndef SOLDERING_IRON_TEMPERATURE_CONTROLLER_TOP_DEFINES_SVH
`define SOLDERING_IRON_TEMPERATURE_CONTROLLER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SITC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define SITC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/sitc_pkg.sv */
// Package: controller states, phases, display sources and codes, modes, knob codes and register indexes.
package sitc_pkg;
  typedef enum logic [4:0] {
    ST_CHECK_RDY = 5'd0, ST_CHECK = 5'd1, ST_IDLE_RDY = 5'd2, ST_IDLE = 5'd3,
    ST_SHOW_RDY = 5'd4, ST_SHOW = 5'd5, ST_CTRL_RDY = 5'd6, ST_CTRL = 5'd7,
    ST_SET_RDY = 5'd8, ST_SET = 5'd9, ST_ALARM_RDY = 5'd10, ST_ALARM = 5'd11,
    ST_WARN_RDY = 5'd12, ST_WARN = 5'd13, ST_CAL_RDY = 5'd14, ST_CAL = 5'd15,
    ST_SLEEP_RDY = 5'd16, ST_SLEEP = 5'd17
  } state_t;
  typedef enum logic [1:0] {PH_HEAT = 2'd0, PH_OVER = 2'd1, PH_NOHEAT = 2'd2,
                            PH_BAL = 2'd3} phase_t;
  typedef enum logic [1:0] {SRC_TARGET = 2'd0, SRC_MEASURED = 2'd1,
                            SRC_OFFSET = 2'd2} src_t;
  localparam logic [2:0] TXT_CLEAN = 3'd0, TXT_OFF = 3'd1, TXT_SLEEP = 3'd2,
                         TXT_CAL = 3'd3, TXT_SERR = 3'd4, TXT_HERR = 3'd5;
  localparam logic [1:0] MODE_TICK = 2'd0, MODE_STEP = 2'd1, MODE_POWER = 2'd2;
  localparam logic [1:0] KNOB_DOWN = 2'd1, KNOB_UP = 2'd2;
  localparam logic [2:0] REG_HYST = 3'd0, REG_SADC = 3'd1, REG_TMIN = 3'd2,
                         REG_TMAX = 3'd3, REG_OMIN = 3'd4, REG_OMAX = 3'd5,
                         REG_TINIT = 3'd6, REG_OINIT = 3'd7;
endpackage

/* sv/soldering_iron_temperature_controller_top.sv */
// Top level: soldering iron temperature controller, one request per cycle while the output register is not stalled.
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | mode, temp, adc, knob, button, hold
//  out_    | output    | out_valid / out_ready| display settings, flags, save pulse
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
// Each request is handled without a pipeline: state updates at acceptance and the
// result lands in a single output register. in_ready is high whenever that
// register is empty or is being emptied, so requests flow back to back.
// rst_n is synchronous; configuration writes are always taken.
`include "soldering_iron_temperature_controller_top_defines.svh"
module soldering_iron_temperature_controller_top
  import sitc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [9:0]         in_measured_temp,
  input  logic [11:0]        in_sensor_adc,
  input  logic [1:0]         in_knob_turn,
  input  logic               in_button_pressed,
  input  logic [9:0]         in_long_press_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_controller_state,
  output logic [1:0]         out_work_phase,
  output logic               out_show_number,
  output logic signed [10:0] out_shown_value,
  output logic [2:0]         out_text_word,
  output logic               out_blink,
  output logic               out_running_dot,
  output logic               out_heating_dot,
  output logic               out_sensor_fault,
  output logic               out_heater_fault,
  output logic               out_save_pulse,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  logic [7:0] hyst_r; logic [11:0] sadc_r; logic [9:0] tmin_r, tmax_r;
  logic signed [7:0] omin_r, omax_r;

  state_t st_r, st_nxt; phase_t ph_r, ph_nxt;
  logic [7:0] stm_r, stm_nxt, htm_r, htm_nxt;
  logic [9:0] tgt_r, tgt_nxt, start_r, start_nxt;
  logic signed [7:0] ofs_r, ofs_nxt, sav_r, sav_nxt;
  logic armed_r, armed_nxt, sflag_r, sflag_nxt, hflag_r, hflag_nxt;
  logic dnum_r, dnum_nxt, dblink_r, dblink_nxt, drun_r, drun_nxt, dheat_r, dheat_nxt;
  src_t dsrc_r, dsrc_nxt; logic [2:0] dtext_r, dtext_nxt;
  logic save;
  logic signed [10:0] shown;

  logic acc;
  assign in_ready  = !out_valid || out_ready;
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // initial target and offset only matter at reset, which restores the defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r <= 8'd5; sadc_r <= 12'd4000; tmin_r <= 10'd200; tmax_r <= 10'd480;
      omin_r <= -8'sd50; omax_r <= 8'sd50;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HYST:  hyst_r  <= cfg_data[7:0];
        REG_SADC:  sadc_r  <= cfg_data;
        REG_TMIN:  tmin_r  <= cfg_data[9:0];
        REG_TMAX:  tmax_r  <= cfg_data[9:0];
        REG_OMIN:  omin_r  <= cfg_data[7:0];
        REG_OMAX:  omax_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic signed [11:0] diff, band, drop, mag;
  logic signed [8:0] odn, oup;
  logic [10:0] tup;
  logic [9:0] meas;
  assign meas = in_measured_temp;
  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; stm_nxt = stm_r; htm_nxt = htm_r;
    tgt_nxt = tgt_r; start_nxt = start_r; ofs_nxt = ofs_r; sav_nxt = sav_r;
    armed_nxt = armed_r; sflag_nxt = sflag_r; hflag_nxt = hflag_r;
    dnum_nxt = dnum_r; dblink_nxt = dblink_r; drun_nxt = drun_r; dheat_nxt = dheat_r;
    dsrc_nxt = dsrc_r; dtext_nxt = dtext_r; save = 1'b0;
    diff = $signed({2'b0, meas}) - $signed({2'b0, tgt_r});
    band = $signed({4'b0, hyst_r});
    drop = $signed({2'b0, start_r}) - $signed({2'b0, meas});
    mag  = drop[11] ? -drop : drop;
    odn  = 9'(ofs_r) - 9'sd1;
    oup  = 9'(ofs_r) + 9'sd1;
    tup  = {1'b0, tgt_r} + 11'd1;
    if (in_mode == MODE_TICK) begin
      if (stm_r != 8'hFF) stm_nxt = stm_r + 8'd1;
      if (htm_r != 8'hFF) htm_nxt = htm_r + 8'd1;
    end else if (in_mode == MODE_POWER) begin
      if (st_r != ST_IDLE) st_nxt = ST_IDLE_RDY;
    end else if (in_mode == MODE_STEP) begin
      unique case (st_r)
        ST_CHECK_RDY: begin
          dnum_nxt = 1'b0; dtext_nxt = TXT_CLEAN; dblink_nxt = 1'b0;
          drun_nxt = 1'b0; dheat_nxt = 1'b0; stm_nxt = 8'd0; st_nxt = ST_CHECK;
        end
        ST_CHECK: if (stm_r > 8'd3) st_nxt = ST_SHOW_RDY;
        ST_IDLE_RDY: begin
          dnum_nxt = 1'b0; dtext_nxt = TXT_OFF; dblink_nxt = 1'b0;
          drun_nxt = 1'b0; dheat_nxt = 1'b0; st_nxt = ST_IDLE;
        end
        ST_SHOW_RDY: begin
          stm_nxt = 8'd0; dnum_nxt = 1'b1; dsrc_nxt = SRC_TARGET; dblink_nxt = 1'b1;
          drun_nxt = 1'b0; dheat_nxt = 1'b0; st_nxt = ST_SHOW;
        end
        ST_SHOW: if (stm_r > 8'd15) st_nxt = ST_CTRL_RDY;
        ST_CTRL_RDY: begin
          htm_nxt = 8'd0; sflag_nxt = 1'b0; hflag_nxt = 1'b0; armed_nxt = 1'b0;
          dnum_nxt = 1'b1; drun_nxt = 1'b0; dblink_nxt = 1'b0;
          stm_nxt = 8'd0; st_nxt = ST_CTRL;
        end
        ST_CTRL: begin
          dsrc_nxt = (ph_r == PH_BAL) ? SRC_TARGET : SRC_MEASURED;
          unique case (ph_r)
            PH_HEAT:   if (!diff[11]) ph_nxt = PH_OVER;
            PH_OVER:   if (diff[11]) ph_nxt = PH_BAL;
            PH_NOHEAT: if (diff <= 0) ph_nxt = PH_BAL;
            default: begin
              if (diff > band) ph_nxt = PH_NOHEAT;
              if (diff < -band) ph_nxt = PH_HEAT;
            end
          endcase
          if (in_sensor_adc < sadc_r) dheat_nxt = meas < tgt_r;
          else begin
            sflag_nxt = 1'b1; st_nxt = ST_ALARM_RDY;
          end
          if (!armed_r) begin
            if (ph_nxt == PH_HEAT) begin
              start_nxt = meas; armed_nxt = 1'b1; htm_nxt = 8'd0;
            end
            dblink_nxt = 1'b0;
          end else if (ph_nxt == PH_HEAT) begin
            dblink_nxt = drop > 12'sd100;
            if (htm_r > 8'd100 && meas < 10'd90 && mag < 12'sd4) begin
              st_nxt = ST_ALARM_RDY; hflag_nxt = 1'b1;
            end
          end else armed_nxt = 1'b0;
          if (in_knob_turn == KNOB_DOWN || in_knob_turn == KNOB_UP) st_nxt = ST_SET_RDY;
          if (in_long_press_count > 10'd300 && ph_nxt == PH_BAL) st_nxt = ST_WARN_RDY;
        end
        ST_SLEEP_RDY: begin
          dnum_nxt = 1'b1; dsrc_nxt = SRC_MEASURED; dblink_nxt = 1'b0;
          drun_nxt = 1'b0; dheat_nxt = 1'b0; st_nxt = ST_SLEEP;
        end
        ST_SLEEP: begin
          dnum_nxt = 1'b0; dtext_nxt = TXT_SLEEP; dblink_nxt = 1'b0;
          drun_nxt = 1'b0; dheat_nxt = 1'b0;
        end
        ST_SET_RDY: begin
          stm_nxt = 8'd0; dnum_nxt = 1'b1; dsrc_nxt = SRC_TARGET; dblink_nxt = 1'b0;
          drun_nxt = 1'b0; dheat_nxt = 1'b0; st_nxt = ST_SET;
        end
        ST_SET: begin
          if (in_knob_turn == KNOB_DOWN) begin
            // at or below the floor (also when target is 0) clamp to it
            tgt_nxt = (tgt_r <= tmin_r + 10'd1 || tgt_r == 10'd0) ? tmin_r
                      : tgt_r - 10'd1;
            if (tmin_r == 10'h3FF && tgt_r != 10'd0) tgt_nxt = tmin_r;
            stm_nxt = 8'd0;
          end else if (in_knob_turn == KNOB_UP) begin
            tgt_nxt = (tup > {1'b0, tmax_r}) ? tmax_r : tup[9:0];
            stm_nxt = 8'd0;
          end
          if (in_button_pressed || stm_nxt > 8'd25) begin
            save = 1'b1; st_nxt = ST_CTRL_RDY;
          end
        end
        ST_WARN_RDY: begin
          dnum_nxt = 1'b0; dtext_nxt = TXT_CAL; dblink_nxt = 1'b0;
          drun_nxt = 1'b1; dheat_nxt = 1'b0; st_nxt = ST_WARN; stm_nxt = 8'd0;
        end
        ST_WARN: if (stm_r > 8'd15) st_nxt = ST_CAL_RDY;
        ST_CAL_RDY: begin
          dnum_nxt = 1'b1; dsrc_nxt = SRC_OFFSET; dblink_nxt = 1'b1;
          drun_nxt = 1'b0; dheat_nxt = 1'b0; stm_nxt = 8'd0; st_nxt = ST_CAL;
        end
        ST_CAL: begin
          if (in_knob_turn == KNOB_DOWN) begin
            ofs_nxt = (odn < 9'(omin_r)) ? omin_r : odn[7:0];
            stm_nxt = 8'd0;
          end else if (in_knob_turn == KNOB_UP) begin
            ofs_nxt = (oup > 9'(omax_r)) ? omax_r : oup[7:0];
            stm_nxt = 8'd0;
          end
          if (in_button_pressed) begin
            save = 1'b1; sav_nxt = ofs_nxt; st_nxt = ST_CTRL_RDY;
          end
          if (stm_nxt > 8'd50) begin
            ofs_nxt = sav_nxt; st_nxt = ST_CTRL_RDY;
          end
        end
        ST_ALARM_RDY: begin
          dnum_nxt = 1'b0; drun_nxt = 1'b0; dblink_nxt = 1'b1; st_nxt = ST_ALARM;
        end
        ST_ALARM: begin
          dtext_nxt = sflag_r ? TXT_SERR : TXT_HERR;
          if (hflag_r) begin
            dheat_nxt = 1'b1;
            if (meas > 10'd90) st_nxt = ST_CTRL_RDY;
          end else begin
            dheat_nxt = 1'b0;
            if (in_sensor_adc < sadc_r) st_nxt = ST_CTRL_RDY;
          end
        end
        default: ;
      endcase
    end
    shown = 11'sd0;
    if (dnum_nxt) begin
      case (dsrc_nxt)
        SRC_MEASURED: shown = $signed({1'b0, meas});
        SRC_OFFSET:   shown = 11'(ofs_nxt);
        default:      shown = $signed({1'b0, tgt_nxt});
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CHECK_RDY; ph_r <= PH_HEAT; stm_r <= 8'd0; htm_r <= 8'd0;
      tgt_r <= 10'd300; ofs_r <= 8'sd0; sav_r <= 8'sd0; armed_r <= 1'b0;
      start_r <= 10'd0; sflag_r <= 1'b0; hflag_r <= 1'b0;
      dnum_r <= 1'b0; dblink_r <= 1'b0; drun_r <= 1'b0; dheat_r <= 1'b0;
      dsrc_r <= SRC_TARGET; dtext_r <= TXT_CLEAN; out_valid <= 1'b0;
    end else begin
      if (acc) begin
        st_r <= st_nxt; ph_r <= ph_nxt; stm_r <= stm_nxt; htm_r <= htm_nxt;
        tgt_r <= tgt_nxt; ofs_r <= ofs_nxt; sav_r <= sav_nxt; armed_r <= armed_nxt;
        start_r <= start_nxt; sflag_r <= sflag_nxt; hflag_r <= hflag_nxt;
        dnum_r <= dnum_nxt; dblink_r <= dblink_nxt; drun_r <= drun_nxt;
        dheat_r <= dheat_nxt; dsrc_r <= dsrc_nxt; dtext_r <= dtext_nxt;
        out_valid <= 1'b1;
      end else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_controller_state <= st_nxt; out_work_phase <= ph_nxt;
      out_show_number <= dnum_nxt; out_shown_value <= shown;
      out_text_word <= dtext_nxt; out_blink <= dblink_nxt;
      out_running_dot <= drun_nxt; out_heating_dot <= dheat_nxt;
      out_sensor_fault <= sflag_nxt; out_heater_fault <= hflag_nxt;
      out_save_pulse <= save;
    end
  end

  `SITC_ASSERT(a_ready, out_valid && !out_ready, !in_ready)
  `SITC_ASSERT(a_save, save, in_mode == MODE_STEP && (st_r == ST_SET || st_r == ST_CAL))
  `SITC_ASSERT_NXT(a_tmr, acc && in_mode == MODE_POWER && st_r != ST_IDLE, st_r == ST_IDLE_RDY)
endmodule

/* tb/sitc_display_checker.sv */
// Checker: predicts each result of the temperature controller and compares it.
`timescale 1ns / 100ps
module sitc_display_checker
  import sitc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [9:0]         in_measured_temp,
  input  logic [11:0]        in_sensor_adc,
  input  logic [1:0]         in_knob_turn,
  input  logic               in_button_pressed,
  input  logic [9:0]         in_long_press_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [4:0]         out_controller_state,
  input  logic [1:0]         out_work_phase,
  input  logic               out_show_number,
  input  logic signed [10:0] out_shown_value,
  input  logic [2:0]         out_text_word,
  input  logic               out_blink,
  input  logic               out_running_dot,
  input  logic               out_heating_dot,
  input  logic               out_sensor_fault,
  input  logic               out_heater_fault,
  input  logic               out_save_pulse,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  output int                 errors,
  output int                 pending,
  output logic [9:0]         shadow_target
);

  typedef struct packed {
    logic [4:0]         state;
    logic [1:0]         phase;
    logic               num;
    logic signed [10:0] shown;
    logic [2:0]         text;
    logic               blink;
    logic               run;
    logic               heat;
    logic               sflag;
    logic               hflag;
    logic               save;
  } display_t;

  display_t display_q[$];

  // register copies
  logic [7:0]        c_hyst;
  logic [11:0]       c_sadc;
  logic [9:0]        c_tmin, c_tmax, c_tinit;
  logic signed [7:0] c_omin, c_omax, c_oinit;

  // controller copy
  state_t            st;
  phase_t            ph;
  src_t              dsrc;
  logic [7:0]        stmr, htmr;
  logic [9:0]        tgt, start_t;
  logic signed [7:0] ofs, ofs_saved;
  logic              armed, sflag, hflag, dnum, dblink, drun, dheat;
  logic [2:0]        dtext;

  assign shadow_target = tgt;

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  task automatic reset_controller();
    c_hyst = 8'd5; c_sadc = 12'd4000; c_tmin = 10'd200; c_tmax = 10'd480;
    c_omin = -8'sd50; c_omax = 8'sd50; c_tinit = 10'd300; c_oinit = 8'sd0;
    st = ST_CHECK_RDY; ph = PH_HEAT; stmr = 0; htmr = 0;
    tgt = c_tinit; ofs = c_oinit; ofs_saved = c_oinit;
    armed = 0; start_t = 0; sflag = 0; hflag = 0;
    dnum = 0; dsrc = SRC_TARGET; dtext = TXT_CLEAN; dblink = 0; drun = 0; dheat = 0;
  endtask

  task automatic write_register(logic [2:0] idx, logic [11:0] data);
    case (idx)
      REG_HYST:  c_hyst = data[7:0];
      REG_SADC:  c_sadc = data;
      REG_TMIN:  c_tmin = data[9:0];
      REG_TMAX:  c_tmax = data[9:0];
      REG_OMIN:  c_omin = data[7:0];
      REG_OMAX:  c_omax = data[7:0];
      REG_TINIT: c_tinit = data[9:0];
      REG_OINIT: c_oinit = data[7:0];
      default: ;
    endcase
  endtask

  task automatic regulate(int meas, logic [11:0] adc, logic [1:0] knob, logic [9:0] hold);
    int diff, band, drop, mag;
    diff = meas - int'(tgt);
    band = int'(c_hyst);
    dsrc = (ph == PH_BAL) ? SRC_TARGET : SRC_MEASURED;
    case (ph)
      PH_HEAT:   if (diff >= 0) ph = PH_OVER;
      PH_OVER:   if (diff < 0) ph = PH_BAL;
      PH_NOHEAT: if (diff <= 0) ph = PH_BAL;
      default: begin
        if (diff > band) ph = PH_NOHEAT;
        if (diff < -band) ph = PH_HEAT;
      end
    endcase
    if (adc < c_sadc) begin
      dheat = meas < int'(tgt);
    end else begin
      sflag = 1;
      st = ST_ALARM_RDY;
    end
    if (!armed) begin
      if (ph == PH_HEAT) begin
        start_t = meas[9:0];
        armed = 1;
        htmr = 0;
      end
      dblink = 0;
    end else if (ph == PH_HEAT) begin
      drop = int'(start_t) - meas;
      mag = drop < 0 ? -drop : drop;
      dblink = drop > 100;
      // heater not warming: temperature moved less than 4 degrees for too long while cold
      if (htmr > 100 && meas < 90 && mag < 4) begin
        st = ST_ALARM_RDY;
        hflag = 1;
      end
    end else begin
      armed = 0;
    end
    if (knob == KNOB_DOWN || knob == KNOB_UP) st = ST_SET_RDY;
    if (hold > 300 && ph == PH_BAL) st = ST_WARN_RDY;
  endtask

  task automatic advance_controller(output display_t d);
    int meas, t;
    logic save;
    meas = int'(in_measured_temp);
    save = 0;
    case (in_mode)
      MODE_TICK: begin
        if (stmr != 8'd255) stmr++;
        if (htmr != 8'd255) htmr++;
      end
      MODE_POWER: if (st != ST_IDLE) st = ST_IDLE_RDY;
      MODE_STEP: begin
        case (st)
          ST_CHECK_RDY: begin
            dnum = 0; dtext = TXT_CLEAN; dblink = 0; drun = 0; dheat = 0;
            stmr = 0; st = ST_CHECK;
          end
          ST_CHECK: if (stmr > 3) st = ST_SHOW_RDY;
          ST_IDLE_RDY: begin
            dnum = 0; dtext = TXT_OFF; dblink = 0; drun = 0; dheat = 0;
            st = ST_IDLE;
          end
          ST_SHOW_RDY: begin
            stmr = 0;
            dnum = 1; dsrc = SRC_TARGET; dblink = 1; drun = 0; dheat = 0;
            st = ST_SHOW;
          end
          ST_SHOW: if (stmr > 15) st = ST_CTRL_RDY;
          ST_CTRL_RDY: begin
            htmr = 0; sflag = 0; hflag = 0; armed = 0;
            dnum = 1; drun = 0; dblink = 0;
            stmr = 0; st = ST_CTRL;
          end
          ST_CTRL: regulate(meas, in_sensor_adc, in_knob_turn, in_long_press_count);
          ST_SLEEP_RDY: begin
            dnum = 1; dsrc = SRC_MEASURED; dblink = 0; drun = 0; dheat = 0;
            st = ST_SLEEP;
          end
          ST_SLEEP: begin
            dnum = 0; dtext = TXT_SLEEP; dblink = 0; drun = 0; dheat = 0;
          end
          ST_SET_RDY: begin
            stmr = 0;
            dnum = 1; dsrc = SRC_TARGET; dblink = 0; drun = 0; dheat = 0;
            st = ST_SET;
          end
          ST_SET: begin
            if (in_knob_turn == KNOB_DOWN) begin
              t = int'(tgt) - 1;
              tgt = (t <= int'(c_tmin)) ? c_tmin : t[9:0];
              stmr = 0;
            end else if (in_knob_turn == KNOB_UP) begin
              t = int'(tgt) + 1;
              tgt = (t > int'(c_tmax)) ? c_tmax : t[9:0];
              stmr = 0;
            end
            if (in_button_pressed || stmr > 25) begin
              save = 1;
              st = ST_CTRL_RDY;
            end
          end
          ST_WARN_RDY: begin
            dnum = 0; dtext = TXT_CAL; dblink = 0; drun = 1; dheat = 0;
            st = ST_WARN; stmr = 0;
          end
          ST_WARN: if (stmr > 15) st = ST_CAL_RDY;
          ST_CAL_RDY: begin
            dnum = 1; dsrc = SRC_OFFSET; dblink = 1; drun = 0; dheat = 0;
            stmr = 0; st = ST_CAL;
          end
          ST_CAL: begin
            if (in_knob_turn == KNOB_DOWN) begin
              t = int'(ofs) - 1;
              ofs = (t < int'(c_omin)) ? c_omin : t[7:0];
              stmr = 0;
            end else if (in_knob_turn == KNOB_UP) begin
              t = int'(ofs) + 1;
              ofs = (t > int'(c_omax)) ? c_omax : t[7:0];
              stmr = 0;
            end
            if (in_button_pressed) begin
              save = 1; ofs_saved = ofs; st = ST_CTRL_RDY;
            end
            // timeout drops the edit
            if (stmr > 50) begin
              ofs = ofs_saved; st = ST_CTRL_RDY;
            end
          end
          ST_ALARM_RDY: begin
            dnum = 0; drun = 0; dblink = 1;
            st = ST_ALARM;
          end
          ST_ALARM: begin
            dtext = sflag ? TXT_SERR : TXT_HERR;
            if (hflag) begin
              dheat = 1;
              if (meas > 90) st = ST_CTRL_RDY;
            end else begin
              dheat = 0;
              if (in_sensor_adc < c_sadc) st = ST_CTRL_RDY;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    d.state = st; d.phase = ph; d.num = dnum; d.text = dtext;
    d.blink = dblink; d.run = drun; d.heat = dheat;
    d.sflag = sflag; d.hflag = hflag; d.save = save;
    if (!dnum) d.shown = '0;
    else if (dsrc == SRC_MEASURED) d.shown = {1'b0, in_measured_temp};
    else if (dsrc == SRC_OFFSET) d.shown = 11'(ofs);
    else d.shown = {1'b0, tgt};
  endtask

  task automatic compare_display();
    display_t w;
    if (display_q.size() == 0) begin
      $display("%0t: result with no request outstanding", $time);
      errors++;
      return;
    end
    w = display_q.pop_front();
    if (out_controller_state != w.state)
      report_mismatch("controller_state", out_controller_state, w.state);
    if (out_work_phase != w.phase) report_mismatch("work_phase", out_work_phase, w.phase);
    if (out_show_number != w.num) report_mismatch("show_number", out_show_number, w.num);
    if (out_shown_value != w.shown) report_mismatch("shown_value", out_shown_value, w.shown);
    if (out_text_word != w.text) report_mismatch("text_word", out_text_word, w.text);
    if (out_blink != w.blink) report_mismatch("blink", out_blink, w.blink);
    if (out_running_dot != w.run) report_mismatch("running_dot", out_running_dot, w.run);
    if (out_heating_dot != w.heat) report_mismatch("heating_dot", out_heating_dot, w.heat);
    if (out_sensor_fault != w.sflag)
      report_mismatch("sensor_fault", out_sensor_fault, w.sflag);
    if (out_heater_fault != w.hflag)
      report_mismatch("heater_fault", out_heater_fault, w.hflag);
    if (out_save_pulse != w.save) report_mismatch("save_pulse", out_save_pulse, w.save);
  endtask

  initial begin
    errors = 0;
    pending = 0;
    reset_controller();
  end

  always @(posedge clk) begin
    display_t d;
    if (!rst_n) begin
      reset_controller();
      display_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      // push first: a result leaving on this edge belongs to an older request
      if (in_valid && in_ready) begin
        advance_controller(d);
        display_q.push_back(d);
      end
      if (out_valid && out_ready) compare_display();
    end
    pending = display_q.size();
  end

endmodule

/* tb/soldering_iron_temperature_controller_top_tb.sv */
// Testbench top: stimulus, handshake pacing and verdict for the controller.
`timescale 1ns / 100ps
module soldering_iron_temperature_controller_top_tb
  import sitc_pkg::*;
();

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [1:0] KNOB_NONE = 2'd0, KNOB_SPARE = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int FLAV_NORMAL = 0, FLAV_COLD = 1, FLAV_CAL = 2, FLAV_KNOB = 3,
                 FLAV_NOISE = 4;

  logic               clk, rst_n;
  logic               in_valid, in_ready;
  logic [1:0]         in_mode;
  logic [9:0]         in_measured_temp;
  logic [11:0]        in_sensor_adc;
  logic [1:0]         in_knob_turn;
  logic               in_button_pressed;
  logic [9:0]         in_long_press_count;
  logic               out_valid, out_ready;
  logic [4:0]         out_controller_state;
  logic [1:0]         out_work_phase;
  logic               out_show_number;
  logic signed [10:0] out_shown_value;
  logic [2:0]         out_text_word;
  logic               out_blink, out_running_dot, out_heating_dot;
  logic               out_sensor_fault, out_heater_fault, out_save_pulse;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [11:0]        cfg_data;

  int          errors, pending, idle_cycles;
  logic [9:0]  shadow_target;
  logic [11:0] cur_sadc;
  bit          quiet, hold_req;

  soldering_iron_temperature_controller_top i_dut (.*);

  sitc_display_checker i_checker (.*);

  initial clk = 0;
  always #1 clk = ~clk;

  task automatic send_request(logic [1:0] mode, int meas, logic [11:0] adc,
                              logic [1:0] knob, logic btn, logic [9:0] hold);
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= mode;
    in_measured_temp <= (meas < 0) ? 10'd0 : (meas > 1023) ? 10'd1023 : 10'(meas);
    in_sensor_adc <= adc;
    in_knob_turn <= knob;
    in_button_pressed <= btn;
    in_long_press_count <= hold;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [11:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(logic [7:0] hyst, logic [11:0] sadc, logic [9:0] tmin,
                               logic [9:0] tmax, logic [7:0] omin, logic [7:0] omax,
                               logic [9:0] tinit, logic [7:0] oinit);
    write_reg(REG_HYST, {4'd0, hyst});
    write_reg(REG_SADC, sadc);
    write_reg(REG_TMIN, {2'd0, tmin});
    write_reg(REG_TMAX, {2'd0, tmax});
    write_reg(REG_OMIN, {4'd0, omin});
    write_reg(REG_OMAX, {4'd0, omax});
    write_reg(REG_TINIT, {2'd0, tinit});
    write_reg(REG_OINIT, {4'd0, oinit});
    cfg_valid <= 0;
    cur_sadc = sadc;
  endtask

  function automatic logic [11:0] pick_adc(int fault_pct);
    if ($urandom_range(0, 99) < fault_pct) return 12'($urandom_range(3990, 4095));
    if (cur_sadc == 0) return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(0, cur_sadc - 1));
  endfunction

  // one request shaped by the current segment flavour
  task automatic random_request(int flav, int cold_base, logic [1:0] knob_dir);
    logic [1:0] mode, knob;
    int         meas;
    logic [11:0] adc;
    logic       btn;
    logic [9:0] hold;
    mode = ($urandom_range(0, 99) < 45) ? MODE_TICK : MODE_STEP;
    meas = int'(shadow_target) + $urandom_range(0, 60) - 30;
    adc = pick_adc(6);
    knob = ($urandom_range(0, 99) < 6) ? 2'($urandom_range(1, 3)) : KNOB_NONE;
    btn = $urandom_range(0, 99) < 5;
    hold = ($urandom_range(0, 99) < 5) ? 10'($urandom_range(301, 1023))
                                        : 10'($urandom_range(0, 200));
    case (flav)
      FLAV_COLD: begin
        mode = ($urandom_range(0, 99) < 60) ? MODE_TICK : MODE_STEP;
        meas = cold_base + $urandom_range(0, 2);
        adc = pick_adc(0);
        knob = KNOB_NONE;
        btn = 0;
        hold = 10'($urandom_range(0, 50));
      end
      FLAV_CAL: begin
        meas = int'(shadow_target) + $urandom_range(0, 6) - 3;
        adc = pick_adc(1);
        hold = ($urandom_range(0, 99) < 70) ? 10'($urandom_range(301, 1023))
                                             : 10'($urandom_range(0, 300));
        knob = ($urandom_range(0, 99) < 25) ? (($urandom_range(0, 1) != 0) ? knob_dir
                                              : 2'($urandom_range(1, 2))) : KNOB_NONE;
        btn = $urandom_range(0, 99) < 3;
      end
      FLAV_KNOB: begin
        meas = int'(shadow_target) + $urandom_range(0, 10) - 5;
        adc = pick_adc(2);
        knob = ($urandom_range(0, 99) < 40) ? knob_dir : KNOB_NONE;
        btn = $urandom_range(0, 99) < 3;
      end
      FLAV_NOISE: begin
        mode = ($urandom_range(0, 9) == 0) ? MODE_NONE
               : ($urandom_range(0, 1) != 0) ? MODE_TICK : MODE_STEP;
        meas = $urandom_range(0, 1023);
        adc = 12'($urandom_range(0, 4095));
        knob = 2'($urandom_range(0, 3));
        btn = $urandom_range(0, 1);
        hold = 10'($urandom_range(0, 1023));
      end
      default: ;
    endcase
    send_request(mode, meas, adc, knob, btn, hold);
  endtask

  task automatic random_phase(int items, bit last);
    int flav, seg, cold_base, sent;
    logic [1:0] knob_dir;
    sent = 0;
    while (sent < items) begin
      flav = $urandom_range(0, 4);
      seg = (flav == FLAV_COLD) ? 250 : $urandom_range(20, 60);
      cold_base = $urandom_range(80, 88);
      knob_dir = ($urandom_range(0, 1) != 0) ? KNOB_UP : KNOB_DOWN;
      repeat (seg) begin
        if (sent >= items) break;
        if (last && items - sent <= 100) quiet = 1;
        random_request(quiet ? FLAV_NORMAL : flav, cold_base, knob_dir);
        sent++;
      end
    end
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    bit held;
    held = 0;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1;
        out_ready <= 0;
        repeat (60) @(posedge clk);
      end else if (!quiet && rst_n && $urandom_range(0, 99) < 10) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[soldering_iron_temperature_controller_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    quiet = 0;
    hold_req = 0;
    cur_sadc = 12'd4000;
    rst_n = 0;
    in_valid = 0;
    in_mode = MODE_TICK;
    in_measured_temp = 0;
    in_sensor_adc = 0;
    in_knob_turn = KNOB_NONE;
    in_button_pressed = 0;
    in_long_press_count = 0;
    cfg_valid = 0;
    cfg_index = REG_HYST;
    cfg_data = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    load_settings(8'd5, 12'd4000, 10'd200, 10'd480, 8'hCE, 8'd50, 10'd300, 8'd0);

    // start-up walk into regulation, with field extremes on the way
    send_request(MODE_STEP, 0, 12'd0, KNOB_NONE, 0, 10'd0);
    send_request(MODE_NONE, 1023, 12'd4095, KNOB_SPARE, 1, 10'd1023);
    repeat (4) send_request(MODE_TICK, 1023, 12'd4095, KNOB_SPARE, 1, 10'd1023);
    send_request(MODE_STEP, 0, 12'd0, KNOB_NONE, 0, 10'd0);
    send_request(MODE_STEP, 512, 12'd2048, KNOB_SPARE, 1, 10'd512);
    repeat (16) send_request(MODE_TICK, 0, 12'd0, KNOB_NONE, 0, 10'd0);
    send_request(MODE_STEP, 250, 12'd100, KNOB_NONE, 0, 10'd0);
    send_request(MODE_STEP, 250, 12'd100, KNOB_UP, 0, 10'd1023);

    // long receiver hold-off while requests keep coming
    hold_req = 1;
    random_phase(260, 0);
    wait_drained();

    load_settings(8'd0, 12'd4095, 10'd0, 10'd1023, 8'h80, 8'h7F, 10'd1023, 8'h80);
    random_phase(130, 0);
    // sender pauses until everything is out, then goes on
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    random_phase(130, 0);
    wait_drained();

    load_settings(8'd255, 12'd1, 10'd1023, 10'd0, 8'hFD, 8'd3, 10'd0, 8'h7F);
    random_phase(260, 0);
    wait_drained();

    load_settings(8'd12, 12'd3000, 10'd250, 10'd260, 8'hF6, 8'd10, 10'd500, 8'hFB);
    random_phase(260, 1);

    // power events end the run: idle is left only by reset
    send_request(MODE_POWER, 300, 12'd0, KNOB_NONE, 0, 10'd0);
    send_request(MODE_STEP, 300, 12'd0, KNOB_NONE, 0, 10'd0);
    send_request(MODE_POWER, 300, 12'd0, KNOB_UP, 1, 10'd0);
    send_request(MODE_TICK, 300, 12'd0, KNOB_NONE, 0, 10'd0);
    send_request(MODE_STEP, 300, 12'd0, KNOB_DOWN, 0, 10'd0);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0)
      $display("[soldering_iron_temperature_controller_top] OK");
    else
      $display("[soldering_iron_temperature_controller_top] ERROR");
    $finish;
  end

endmodule
